// ----- src/flsa_pkg.sv -----
// Package with the shared constants and types of the free-list stack allocator.
`default_nettype none
package flsa_pkg;

   localparam int SLOTS_DEFAULT      = 16;
   localparam int WORD_BYTES_DEFAULT = 4;

   // Command codes.
   localparam logic CMD_FREE  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   // Status codes.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_BAD     = 3'd1;
   localparam logic [2:0] ST_OVERLAP = 3'd2;
   localparam logic [2:0] ST_NOFIT   = 3'd3;
   localparam logic [2:0] ST_FULL    = 3'd4;

   // Register indexes.
   localparam logic REG_HEAP_LOW  = 1'b0;
   localparam logic REG_HEAP_HIGH = 1'b1;

   // Operations that the controller broadcasts to every cell.
   localparam logic [2:0] OP_HOLD   = 3'd0;
   localparam logic [2:0] OP_INSERT = 3'd1;
   localparam logic [2:0] OP_REMOVE = 3'd2;
   localparam logic [2:0] OP_SETLEN = 3'd3;
   localparam logic [2:0] OP_SETBOTH = 3'd4;

   // One extent as it travels between cells.
   typedef struct packed {
      logic [31:0] start;
      logic [31:0] length;
   } extent_type;

   // Command from the controller to the row of cells.
   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  index;
      extent_type  data;
   } cell_cmd_type;

endpackage
`default_nettype wire

// ----- src/flsa_cell.sv -----
// One cell of the extent table: holds one extent and shifts with its neighbors.
`default_nettype none
module flsa_cell #(
   parameter int IDX_W = 4,
   parameter int MY_INDEX = 0
) (
   input  wire                         clock,
   input  flsa_pkg::cell_cmd_type      cmd,
   input  flsa_pkg::extent_type        from_lower,
   input  flsa_pkg::extent_type        from_upper,
   output flsa_pkg::extent_type        extent
);
   import flsa_pkg::*;

   extent_type extent_ff, extent_in;
   logic [IDX_W-1:0] my_idx;
   logic [IDX_W-1:0] cmd_idx;

   assign my_idx  = IDX_W'(MY_INDEX);
   assign cmd_idx = cmd.index[IDX_W-1:0];

   // Next value: shift up on insert, down on remove, or load at the chosen slot.
   always_comb begin
      extent_in = extent_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (my_idx == cmd_idx) extent_in = cmd.data;
            else if (my_idx > cmd_idx) extent_in = from_lower;
         end
         OP_REMOVE: begin
            if (my_idx >= cmd_idx) extent_in = from_upper;
         end
         OP_SETLEN: begin
            if (my_idx == cmd_idx) extent_in.length = cmd.data.length;
         end
         OP_SETBOTH: begin
            if (my_idx == cmd_idx) extent_in = cmd.data;
         end
         default: begin
            extent_in = extent_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      extent_ff <= extent_in;
   end

   assign extent = extent_ff;
endmodule
`default_nettype wire

// ----- src/free_list_stack_allocator.sv -----
// Top level of the free-list stack allocator: controller and row of table cells.
// From start to rsp_valid: the check state, one scan step per entry, then the done state.
// Throughput: one command at a time; busy falls in the cycle of the result strobe, or in the
// following cycle after a free that merges with both neighbors.
// The scan walks the row of cells one entry per cycle; a merge with both neighbors needs a
// further table update. Reset clears the entry count and the control state;
// heap_low=0, heap_high=all ones. The receiver cannot stall: each result is shown once.
`default_nettype none
module free_list_stack_allocator #(
   parameter int SLOTS      = flsa_pkg::SLOTS_DEFAULT,
   parameter int WORD_BYTES = flsa_pkg::WORD_BYTES_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         start,
   output logic        busy,
   input  wire         req_command,
   input  wire  [31:0] req_block_address,
   input  wire  [31:0] req_request_bytes,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_top_word_address,
   output logic [31:0] rsp_granted_bytes,
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire         csr_index,
   input  wire  [31:0] csr_data
);
   import flsa_pkg::*;

   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_CHECK = 2'd1;
   localparam logic [1:0] S_SCAN  = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic [31:0]      heap_low_ff, heap_high_ff;
   logic             cmd_ff;
   logic [31:0]      addr_ff;
   logic [32:0]      size_ff, size_in;
   logic [32:0]      end_ff;
   logic             found_ff, found_in;
   logic [IDX_W-1:0] fit_ff, fit_in;
   logic [CNT_W-1:0] p_ff, p_in;
   logic             pfound_ff, pfound_in;
   logic [2:0]       st_ff;
   logic [31:0]      top_ff, gr_ff;
   logic             rv_ff;
   logic             accept;

   // Removal of the upper neighbor after a double merge happens the next cycle.
   logic             pend_rm_ff;
   logic [IDX_W-1:0] pend_idx_ff;

   cell_cmd_type     ccmd;
   extent_type       cells [SLOTS];
   extent_type       lower [SLOTS];
   extent_type       upper [SLOTS];

   // Row of cells; each neighbor hands its extent over every cycle.
   for (genvar g = 0; g < SLOTS; g++) begin : g_cell
      assign lower[g] = (g == 0) ? ccmd.data : cells[(g == 0) ? 0 : g - 1];
      assign upper[g] = (g == SLOTS - 1) ? cells[g] : cells[(g == SLOTS - 1) ? g : g + 1];
      flsa_cell #(.IDX_W(IDX_W), .MY_INDEX(g)) u_cell (
         .clock(clock), .cmd(ccmd), .from_lower(lower[g]), .from_upper(upper[g]),
         .extent(cells[g]));
   end

   assign busy      = (state_ff != S_IDLE) || pend_rm_ff;
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   // Register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         heap_low_ff  <= '0;
         heap_high_ff <= '1;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == REG_HEAP_LOW) heap_low_ff <= csr_data;
         else heap_high_ff <= csr_data;
      end
   end

   // Size rounded up to whole words.
   logic [32:0] raw_ext, rounded;
   assign raw_ext = {1'b0, req_request_bytes};
   assign rounded = (raw_ext + 33'(WORD_BYTES - 1)) & ~33'(WORD_BYTES - 1);

   // Scan entry at pos.
   logic [IDX_W-1:0] pos_idx;
   extent_type       cur, q_ext, p_ext;
   logic [32:0]      q_end;
   logic             bad, ovl, join_q, join_p, has_q, has_p;
   assign pos_idx = pos_ff[IDX_W-1:0];
   assign cur     = cells[pos_idx];
   assign q_ext   = cells[IDX_W'(p_ff - 1'b1)];
   assign p_ext   = cells[p_ff[IDX_W-1:0]];
   assign has_q   = (p_ff != '0);
   assign has_p   = pfound_ff;
   assign q_end   = {1'b0, q_ext.start} + {1'b0, q_ext.length};
   assign join_q  = has_q && (q_end == {1'b0, addr_ff});
   assign join_p  = has_p && (end_ff == {1'b0, p_ext.start});
   assign ovl     = (has_q && q_end > {1'b0, addr_ff}) || (has_p && end_ff > {1'b0, p_ext.start});
   assign bad     = (size_ff == '0) || size_ff[32];
   logic [31:0] merge_len;
   assign merge_len = q_ext.length + size_ff[31:0] + (join_p ? p_ext.length : 32'd0);

   // Controller.
   always_comb begin
      state_in  = state_ff;
      pos_in    = pos_ff;
      count_in  = count_ff;
      size_in   = size_ff;
      found_in  = found_ff;
      fit_in    = fit_ff;
      p_in      = p_ff;
      pfound_in = pfound_ff;
      ccmd      = '0;
      ccmd.op   = OP_HOLD;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in  = S_CHECK;
               size_in   = (req_request_bytes == '0) ? 33'd0 : rounded;
               pos_in    = '0;
               found_in  = 1'b0;
               fit_in    = '0;
               p_in      = '0;
               pfound_in = 1'b0;
            end
         end
         S_CHECK: begin
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (pos_ff < count_ff) begin
               if (cmd_ff == CMD_ALLOC) begin
                  if ({1'b0, cur.length} >= size_ff) begin
                     found_in = 1'b1;
                     fit_in   = pos_idx;
                  end
               end else if (!pfound_ff) begin
                  if (cur.start < addr_ff) p_in = pos_ff + 1'b1;
                  else pfound_in = 1'b1;
               end
               pos_in = pos_ff + 1'b1;
            end else begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
            if (cmd_ff == CMD_ALLOC) begin
               if (!bad && found_ff) begin
                  if ({1'b0, cells[fit_ff].length} == size_ff) begin
                     ccmd.op    = OP_REMOVE;
                     ccmd.index = 8'(fit_ff);
                     count_in   = count_ff - 1'b1;
                  end else begin
                     ccmd.op          = OP_SETLEN;
                     ccmd.index       = 8'(fit_ff);
                     ccmd.data.length = cells[fit_ff].length - size_ff[31:0];
                  end
               end
            end else if (!bad && addr_ff <= heap_high_ff && addr_ff >= heap_low_ff
                         && !end_ff[32] && !ovl) begin
               if (join_q) begin
                  ccmd.op          = OP_SETLEN;
                  ccmd.index       = 8'(p_ff - 1'b1);
                  ccmd.data.length = merge_len;
               end else if (join_p) begin
                  ccmd.op          = OP_SETBOTH;
                  ccmd.index       = 8'(p_ff);
                  ccmd.data.start  = addr_ff;
                  ccmd.data.length = p_ext.length + size_ff[31:0];
               end else if (count_ff < CNT_W'(SLOTS)) begin
                  ccmd.op          = OP_INSERT;
                  ccmd.index       = 8'(p_ff);
                  ccmd.data.start  = addr_ff;
                  ccmd.data.length = size_ff[31:0];
                  count_in         = count_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // The upper neighbor of a double merge leaves the row in the cycle after the merge.
      if (pend_rm_ff) begin
         ccmd.op    = OP_REMOVE;
         ccmd.index = 8'(pend_idx_ff);
      end
   end

   // Result selection.
   logic [2:0]  st_n;
   logic [31:0] top_n, gr_n;
   always_comb begin
      st_n  = ST_OK;
      top_n = '0;
      gr_n  = '0;
      if (bad) st_n = ST_BAD;
      else if (cmd_ff == CMD_ALLOC) begin
         if (!found_ff) st_n = ST_NOFIT;
         else begin
            top_n = cells[fit_ff].start + cells[fit_ff].length - 32'(WORD_BYTES);
            gr_n  = size_ff[31:0];
         end
      end else if (addr_ff > heap_high_ff || addr_ff < heap_low_ff || end_ff[32]) st_n = ST_BAD;
      else if (ovl) st_n = ST_OVERLAP;
      else if (!join_q && !join_p && count_ff >= CNT_W'(SLOTS)) st_n = ST_FULL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         count_ff   <= '0;
         rv_ff      <= 1'b0;
         pend_rm_ff <= 1'b0;
      end else begin
         state_ff   <= (pend_rm_ff) ? state_ff : state_in;
         count_ff   <= pend_rm_ff ? count_ff - 1'b1 : count_in;
         rv_ff      <= (state_ff == S_DONE) && !pend_rm_ff;
         pend_rm_ff <= 1'b0;
         if (state_ff == S_DONE && !pend_rm_ff && cmd_ff == CMD_FREE && ccmd.op == OP_SETLEN
             && join_q && join_p) pend_rm_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      size_ff     <= size_in;
      found_ff    <= found_in;
      fit_ff      <= fit_in;
      p_ff        <= p_in;
      pfound_ff   <= pfound_in;
      pend_idx_ff <= p_ff[IDX_W-1:0];
      if (state_ff == S_IDLE && accept) begin
         cmd_ff  <= req_command;
         addr_ff <= req_block_address;
      end
      if (state_ff == S_CHECK) end_ff <= {1'b0, addr_ff} + size_ff;
      if (state_ff == S_DONE) begin
         st_ff  <= st_n;
         top_ff <= top_n;
         gr_ff  <= gr_n;
      end
   end

   assign rsp_valid            = rv_ff;
   assign rsp_status           = st_ff;
   assign rsp_top_word_address = top_ff;
   assign rsp_granted_bytes    = gr_ff;

   // Checks on the controller.
   a_count: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(SLOTS)) else $error("entry count beyond table size");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(rsp_valid)) else $error("result strobe longer than one cycle");
   a_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (state_ff == S_IDLE)) else $error("result while busy");
endmodule
`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for the free-list stack allocator with its own table predictor.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
   import flsa_pkg::*;

   localparam int NSLOTS     = SLOTS_DEFAULT;
   localparam int WB         = WORD_BYTES_DEFAULT;
   localparam int SETTLE     = 3 + NSLOTS + 8;
   localparam int CYCLE_CAP  = 600000;

   typedef struct {
      logic        cmd;
      logic [31:0] addr;
      logic [31:0] bytes;
   } heap_cmd_t;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] top;
      logic [31:0] granted;
   } heap_rsp_t;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_command = CMD_FREE;
   logic [31:0] req_block_address = '0;
   logic [31:0] req_request_bytes = '0;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_top_word_address;
   logic [31:0] rsp_granted_bytes;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = REG_HEAP_LOW;
   logic [31:0] csr_data = '0;

   free_list_stack_allocator dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_block_address(req_block_address),
      .req_request_bytes(req_request_bytes), .rsp_valid(rsp_valid),
      .rsp_status(rsp_status), .rsp_top_word_address(rsp_top_word_address),
      .rsp_granted_bytes(rsp_granted_bytes), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Predictor state: configuration and the sorted extent table.
   logic [31:0] heap_lo = 32'h0;
   logic [31:0] heap_hi = 32'hFFFF_FFFF;
   logic [31:0] ext_start [NSLOTS];
   logic [31:0] ext_len   [NSLOTS];
   int          ext_count = 0;

   heap_cmd_t   cmd_q [$];
   heap_rsp_t   rsp_expect_q [$];
   heap_cmd_t   shown;
   int          idle_pct = 0;
   int          mismatches = 0;
   int          cycles = 0;

   // Rounds a byte count up to whole words; returns 0 when zero or too large.
   function automatic longint unsigned round_words(logic [31:0] raw);
      longint unsigned r;
      r = raw;
      if (r == 0) return 0;
      if (r % WB != 0) r = r + WB - (r % WB);
      if (r > 64'hFFFF_FFFF) return 0;
      return r;
   endfunction

   function automatic void drop_extent(int idx);
      for (int i = idx; i + 1 < ext_count; i++) begin
         ext_start[i] = ext_start[i + 1];
         ext_len[i]   = ext_len[i + 1];
      end
      ext_count--;
   endfunction

   // Applies one command to the predicted table and returns its result.
   function automatic heap_rsp_t apply_heap_cmd(heap_cmd_t c);
      heap_rsp_t       res;
      longint unsigned sz, end_a, q_end;
      int              p, fit;
      bit              has_q, has_p, join_q, join_p;
      res = '{ST_OK, 32'h0, 32'h0};
      sz = round_words(c.bytes);
      if (sz == 0) begin
         res.status = ST_BAD;
      end else if (c.cmd == CMD_FREE) begin
         end_a = longint'(c.addr) + sz;
         if (c.addr > heap_hi || c.addr < heap_lo || end_a > 64'hFFFF_FFFF) begin
            res.status = ST_BAD;
            return res;
         end
         p = 0;
         while (p < ext_count && ext_start[p] < c.addr) p++;
         has_q = p > 0;
         has_p = p < ext_count;
         q_end = has_q ? longint'(ext_start[p - 1]) + ext_len[p - 1] : 0;
         if ((has_q && q_end > c.addr) || (has_p && end_a > ext_start[p])) begin
            res.status = ST_OVERLAP;
            return res;
         end
         join_q = has_q && q_end == c.addr;
         join_p = has_p && end_a == ext_start[p];
         if (join_q && join_p) begin
            ext_len[p - 1] = ext_len[p - 1] + sz[31:0] + ext_len[p];
            drop_extent(p);
         end else if (join_q) begin
            ext_len[p - 1] = ext_len[p - 1] + sz[31:0];
         end else if (join_p) begin
            ext_start[p] = c.addr;
            ext_len[p]   = ext_len[p] + sz[31:0];
         end else if (ext_count >= NSLOTS) begin
            res.status = ST_FULL;
         end else begin
            for (int i = ext_count; i > p; i--) begin
               ext_start[i] = ext_start[i - 1];
               ext_len[i]   = ext_len[i - 1];
            end
            ext_start[p] = c.addr;
            ext_len[p]   = sz[31:0];
            ext_count++;
         end
      end else begin
         // Last fit: the highest-addressed extent that is large enough.
         fit = -1;
         for (int i = 0; i < ext_count; i++)
            if (ext_len[i] >= sz) fit = i;
         if (fit < 0) begin
            res.status = ST_NOFIT;
         end else begin
            res.top     = ext_start[fit] + ext_len[fit] - WB;
            res.granted = sz[31:0];
            if (ext_len[fit] == sz) drop_extent(fit);
            else ext_len[fit] = ext_len[fit] - sz[31:0];
         end
      end
      return res;
   endfunction

   // Driver: presents queued commands and predicts each accepted transaction.
   always @(posedge clock) begin
      logic next_start;
      if (reset) begin
         start <= 1'b0;
      end else begin
         next_start = start;
         if (start && !busy) begin
            rsp_expect_q.push_back(apply_heap_cmd(shown));
            next_start = 1'b0;
         end
         if (!next_start && cmd_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
            shown = cmd_q.pop_front();
            req_command       <= shown.cmd;
            req_block_address <= shown.addr;
            req_request_bytes <= shown.bytes;
            next_start = 1'b1;
         end
         start <= next_start;
      end
   end

   // Monitor: compares every result strobe with the oldest expectation.
   always @(posedge clock) begin
      heap_rsp_t want;
      if (!reset && rsp_valid) begin
         if (rsp_expect_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: status %0d top %h granted %h",
                        rsp_status, rsp_top_word_address, rsp_granted_bytes);
         end else begin
            want = rsp_expect_q.pop_front();
            if (rsp_status !== want.status || rsp_top_word_address !== want.top ||
                rsp_granted_bytes !== want.granted) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %0d/%h/%h, got %0d/%h/%h",
                           want.status, want.top, want.granted, rsp_status,
                           rsp_top_word_address, rsp_granted_bytes);
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic queue_cmd(logic c, logic [31:0] a, logic [31:0] b);
      cmd_q.push_back('{c, a, b});
   endtask

   // Waits until every queued transaction has completed and the block is quiet.
   task automatic drain();
      while (cmd_q.size() != 0 || start || busy || rsp_expect_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [31:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == REG_HEAP_LOW) heap_lo = value;
      else heap_hi = value;
      csr_valid <= 1'b0;
   endtask

   // Mostly well-formed frees and allocations around base, with some noise.
   task automatic queue_random(logic [31:0] base, int count);
      int          r;
      logic [31:0] a;
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(99);
         if (r < 8) begin
            queue_cmd(1'($urandom_range(1)), $urandom, $urandom);
         end else if (r < 52) begin
            a = base + 4 * $urandom_range(63);
            if ($urandom_range(9) == 0) a = a + $urandom_range(1, 3);
            if ($urandom_range(19) == 0) a = base - 4;
            queue_cmd(CMD_FREE, a, $urandom_range(24));
         end else begin
            queue_cmd(CMD_ALLOC, $urandom, $urandom_range(40));
         end
      end
   endtask

   initial begin
      logic [31:0] lo_set [5];
      logic [31:0] hi_set [5];
      int          pct_set [5];
      lo_set  = '{32'h0000_1000, 32'h0, 32'hFFFF_FE00, 32'h0000_2000, 32'h0000_1000};
      hi_set  = '{32'h0000_1FFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_1000, 32'h0000_1000};
      pct_set = '{58, 0, 24, 58, 0};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part under reset configuration.
      queue_cmd(CMD_FREE,  32'h100, 32'h0);
      queue_cmd(CMD_FREE,  32'h100, 32'hFFFF_FFFF);
      queue_cmd(CMD_FREE,  32'hFFFF_FFFC, 32'h8);
      queue_cmd(CMD_FREE,  32'hFFFF_FFF8, 32'h8);
      queue_cmd(CMD_ALLOC, 32'h0, 32'h4);
      queue_cmd(CMD_ALLOC, 32'h0, 32'h0);
      queue_cmd(CMD_ALLOC, 32'h0, 32'hFFFF_FFFD);
      queue_cmd(CMD_FREE,  32'h100, 32'h5);
      queue_cmd(CMD_FREE,  32'h100, 32'h4);
      queue_cmd(CMD_FREE,  32'h108, 32'h10);
      queue_cmd(CMD_FREE,  32'h0F8, 32'h8);
      queue_cmd(CMD_FREE,  32'h200, 32'h8);
      queue_cmd(CMD_FREE,  32'h0F0, 32'h10);
      queue_cmd(CMD_FREE,  32'h1FC, 32'h8);
      queue_cmd(CMD_FREE,  32'h118, 32'hE8);
      queue_cmd(CMD_FREE,  32'hFFFF_FFF0, 32'h10);
      queue_cmd(CMD_FREE,  32'h400, 32'h7);
      queue_cmd(CMD_ALLOC, 32'hFFFF_FFFF, 32'h8);
      queue_cmd(CMD_ALLOC, 32'h0, 32'h3);
      queue_cmd(CMD_ALLOC, 32'h0, 32'h1000);
      queue_cmd(CMD_ALLOC, 32'h0, 32'h4);
      queue_cmd(CMD_ALLOC, 32'h0, 32'h100);
      queue_cmd(CMD_FREE,  32'h0, 32'hFFFF_FFFC);
      drain();

      // Random phases, each under its own heap bounds and sender idling.
      for (int ph = 0; ph < 5; ph++) begin
         write_csr(REG_HEAP_LOW, lo_set[ph]);
         write_csr(REG_HEAP_HIGH, hi_set[ph]);
         idle_pct = pct_set[ph];
         // Fill the table past capacity with separated extents, then reuse them.
         if (ph < 2) begin
            for (int k = 0; k < NSLOTS + 2; k++)
               queue_cmd(CMD_FREE, lo_set[ph] + 32'h400 + 16 * k, 32'h4);
            for (int k = 0; k < 6; k++)
               queue_cmd(CMD_ALLOC, 32'h0, 32'h4);
         end
         queue_random(lo_set[ph], 210);
         drain();
      end

      if (mismatches == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
`default_nettype wire
